// File: rtl/cep_pkg.sv
// shared types and constants for the cherenkov emission point block
package cep_pkg;

	localparam logic [15:0] COS_SQ_RESET = 16'd36195;

	localparam int DIFF_W  = 17;
	localparam int N2_W    = 32;
	localparam int T_W     = 35;
	localparam int CROSS_W = 34;
	localparam int AXIS_W  = 21;
	localparam int Q_W     = 42;
	localparam int M_W     = 58;
	localparam int R2Q_W   = 62;
	localparam int ROOT_W  = 32;
	localparam int RAD_W   = 64;
	localparam int NUM_W   = 45;
	localparam int MAG_W   = 44;
	localparam int NUMER_W = 59;
	localparam int LQ_W    = 24;
	localparam int DIST_W  = 24;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK     = 3'd0;
	localparam status_t ST_NOROOT = 3'd1;
	localparam status_t ST_DEGEN  = 3'd2;
	localparam status_t ST_TIE    = 3'd3;
	localparam status_t ST_SAT    = 3'd4;

	localparam logic [DIST_W-1:0] DIST_MAX = 24'h7FFFFF;
	localparam logic [DIST_W-1:0] DIST_MIN = 24'h800000;

	typedef struct packed {
		status_t            status;
		logic [N2_W-1:0]    n2;
		logic [T_W-1:0]     t;
		logic [AXIS_W-1:0]  ax;
		logic [AXIS_W-1:0]  ay;
		logic [AXIS_W-1:0]  az;
		logic [N2_W-1:0]    k;
	} job_t;

endpackage

// File: rtl/cep_div.sv
// pipelined restoring divider, one quotient bit per stage, with a sideband tag
module cep_div #(
	parameter int DW = 32,
	parameter int QW = 24,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [DW-1:0] hi,
	input  logic [QW-1:0] lo,
	input  logic [DW-1:0] dvs,
	input  logic [TW-1:0] tag_in,
	output logic          vld_out,
	output logic [QW-1:0] quo,
	output logic [TW-1:0] tag_out
);

	logic          vld_q   [QW];
	logic [DW-1:0] rem_q   [QW];
	logic [QW-1:0] sh_q    [QW];
	logic [DW-1:0] dvs_q   [QW];
	logic [TW-1:0] tag_q   [QW];

	logic          src_vld [QW];
	logic [DW-1:0] src_rem [QW];
	logic [QW-1:0] src_sh  [QW];
	logic [DW-1:0] src_dvs [QW];
	logic [TW-1:0] src_tag [QW];

	logic [DW:0]   trial   [QW];
	logic          take    [QW];
	logic [DW-1:0] rem_d   [QW];
	logic [QW-1:0] sh_d    [QW];

	always_comb begin
		src_vld[0] = vld_in;
		src_rem[0] = hi;
		src_sh[0]  = lo;
		src_dvs[0] = dvs;
		src_tag[0] = tag_in;
		for (int i = 1; i < QW; i++) begin
			src_vld[i] = vld_q[i-1];
			src_rem[i] = rem_q[i-1];
			src_sh[i]  = sh_q[i-1];
			src_dvs[i] = dvs_q[i-1];
			src_tag[i] = tag_q[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < QW; i++) begin
			trial[i] = {src_rem[i], src_sh[i][QW-1]};
			take[i]  = trial[i] >= {1'b0, src_dvs[i]};
			rem_d[i] = take[i] ? DW'(trial[i] - {1'b0, src_dvs[i]}) : trial[i][DW-1:0];
			sh_d[i]  = {src_sh[i][QW-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QW; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < QW; i++) vld_q[i] <= src_vld[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < QW; i++) begin
				rem_q[i] <= rem_d[i];
				sh_q[i]  <= sh_d[i];
				dvs_q[i] <= src_dvs[i];
				tag_q[i] <= src_tag[i];
			end
		end
	end

	assign vld_out = vld_q[QW-1];
	assign quo     = sh_q[QW-1];
	assign tag_out = tag_q[QW-1];

endmodule

// File: rtl/cep_sqrt.sv
// pipelined integer square root, one root bit per stage, with a sideband tag
module cep_sqrt #(
	parameter int TW = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vld_in,
	input  logic [cep_pkg::RAD_W-1:0] rad,
	input  logic [TW-1:0]             tag_in,
	output logic                      vld_out,
	output logic [cep_pkg::ROOT_W-1:0] root,
	output logic [TW-1:0]             tag_out
);
	import cep_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic              vld_q    [ROOT_W];
	logic [REM_W-1:0]  rem_q    [ROOT_W];
	logic [ROOT_W-1:0] root_q   [ROOT_W];
	logic [RAD_W-1:0]  rad_q    [ROOT_W];
	logic [TW-1:0]     tag_q    [ROOT_W];

	logic              src_vld  [ROOT_W];
	logic [REM_W-1:0]  src_rem  [ROOT_W];
	logic [ROOT_W-1:0] src_root [ROOT_W];
	logic [RAD_W-1:0]  src_rad  [ROOT_W];
	logic [TW-1:0]     src_tag  [ROOT_W];

	logic [REM_W+1:0]  r4       [ROOT_W];
	logic [REM_W+1:0]  trial    [ROOT_W];
	logic              take     [ROOT_W];
	logic [REM_W-1:0]  rem_d    [ROOT_W];
	logic [ROOT_W-1:0] root_d   [ROOT_W];

	always_comb begin
		src_vld[0]  = vld_in;
		src_rem[0]  = '0;
		src_root[0] = '0;
		src_rad[0]  = rad;
		src_tag[0]  = tag_in;
		for (int i = 1; i < ROOT_W; i++) begin
			src_vld[i]  = vld_q[i-1];
			src_rem[i]  = rem_q[i-1];
			src_root[i] = root_q[i-1];
			src_rad[i]  = rad_q[i-1];
			src_tag[i]  = tag_q[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < ROOT_W; i++) begin
			r4[i]     = {src_rem[i], src_rad[i][RAD_W-1 -: 2]};
			trial[i]  = {2'b00, src_root[i], 2'b01};
			take[i]   = r4[i] >= trial[i];
			rem_d[i]  = take[i] ? REM_W'(r4[i] - trial[i]) : r4[i][REM_W-1:0];
			root_d[i] = {src_root[i][ROOT_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_W; i++) vld_q[i] <= 1'b0;
		end else if (en) begin
			for (int i = 0; i < ROOT_W; i++) vld_q[i] <= src_vld[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rem_q[i]  <= rem_d[i];
				root_q[i] <= root_d[i];
				rad_q[i]  <= {src_rad[i][RAD_W-3:0], 2'b00};
				tag_q[i]  <= src_tag[i];
			end
		end
	end

	assign vld_out = vld_q[ROOT_W-1];
	assign root    = root_q[ROOT_W-1];
	assign tag_out = tag_q[ROOT_W-1];

endmodule

// File: rtl/cep_queue.sv
// small register queue between the front and back pipelines
module cep_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// File: rtl/cep_front.sv
// front pipeline: accept a hit, form dot and cross products, classify
module cep_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  vertex_x,
	input  logic signed [15:0]  vertex_y,
	input  logic signed [15:0]  vertex_z,
	input  logic signed [15:0]  dir_x,
	input  logic signed [15:0]  dir_y,
	input  logic signed [15:0]  dir_z,
	input  logic signed [15:0]  sensor_x,
	input  logic signed [15:0]  sensor_y,
	input  logic signed [15:0]  sensor_z,
	input  logic [15:0]         cos_sq,
	input  logic                q_full,
	output logic                push,
	output cep_pkg::job_t       job
);
	import cep_pkg::*;

	logic fe;

	logic                      vld_s1;
	logic signed [15:0]        dx_s1, dy_s1, dz_s1;
	logic signed [DIFF_W-1:0]  ex_s1, ey_s1, ez_s1;

	logic                      vld_s2;
	logic signed [31:0]        nxx_s2, nyy_s2, nzz_s2;
	logic signed [32:0]        tx_s2, ty_s2, tz_s2;
	logic signed [32:0]        pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;

	logic                      vld_s3;
	logic [N2_W-1:0]           n2_s3;
	logic signed [T_W-1:0]     t_s3;
	logic signed [CROSS_W-1:0] cx_s3, cy_s3, cz_s3;

	logic [CROSS_W-1:0]        k;
	logic [CROSS_W-1:0]        mx, my, mz;
	logic                      degen, noroot, tie, cross_zero;

	assign fe       = !(vld_s3 && q_full);
	assign in_stall = !fe;
	assign push     = vld_s3 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (fe) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			dx_s1  <= dir_x;
			dy_s1  <= dir_y;
			dz_s1  <= dir_z;
			ex_s1  <= {sensor_x[15], sensor_x} - {vertex_x[15], vertex_x};
			ey_s1  <= {sensor_y[15], sensor_y} - {vertex_y[15], vertex_y};
			ez_s1  <= {sensor_z[15], sensor_z} - {vertex_z[15], vertex_z};

			nxx_s2 <= dx_s1 * dx_s1;
			nyy_s2 <= dy_s1 * dy_s1;
			nzz_s2 <= dz_s1 * dz_s1;
			tx_s2  <= dx_s1 * ex_s1;
			ty_s2  <= dy_s1 * ey_s1;
			tz_s2  <= dz_s1 * ez_s1;
			pyz_s2 <= dy_s1 * ez_s1;
			pzy_s2 <= dz_s1 * ey_s1;
			pzx_s2 <= dz_s1 * ex_s1;
			pxz_s2 <= dx_s1 * ez_s1;
			pxy_s2 <= dx_s1 * ey_s1;
			pyx_s2 <= dy_s1 * ex_s1;

			n2_s3  <= N2_W'(nxx_s2) + N2_W'(nyy_s2) + N2_W'(nzz_s2);
			t_s3   <= T_W'(tx_s2) + T_W'(ty_s2) + T_W'(tz_s2);
			cx_s3  <= CROSS_W'(pyz_s2) - CROSS_W'(pzy_s2);
			cy_s3  <= CROSS_W'(pzx_s2) - CROSS_W'(pxz_s2);
			cz_s3  <= CROSS_W'(pxy_s2) - CROSS_W'(pyx_s2);
		end
	end

	// classify and reduce the cross product
	always_comb begin
		k          = {2'b00, n2_s3} - {6'b000000, cos_sq, 12'h000};
		cross_zero = (cx_s3 == '0) && (cy_s3 == '0) && (cz_s3 == '0);
		degen      = (n2_s3 == '0) || (k == '0);
		noroot     = k[CROSS_W-1] && (cos_sq != '0) && !cross_zero;
		tie        = (cos_sq == '0) || cross_zero;
		mx         = cx_s3[CROSS_W-1] ? CROSS_W'(-cx_s3) : CROSS_W'(cx_s3);
		my         = cy_s3[CROSS_W-1] ? CROSS_W'(-cy_s3) : CROSS_W'(cy_s3);
		mz         = cz_s3[CROSS_W-1] ? CROSS_W'(-cz_s3) : CROSS_W'(cz_s3);

		if (degen) begin
			job.status = ST_DEGEN;
		end else if (noroot) begin
			job.status = ST_NOROOT;
		end else if (tie) begin
			job.status = ST_TIE;
		end else begin
			job.status = ST_OK;
		end
		job.n2 = n2_s3;
		job.t  = t_s3;
		job.ax = mx[12 +: AXIS_W];
		job.ay = my[12 +: AXIS_W];
		job.az = mz[12 +: AXIS_W];
		job.k  = k[N2_W-1:0];
	end

endmodule

// File: rtl/cep_back.sv
// back pipeline: root radius, square root, final division and saturation
module cep_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [15:0]                 cos_sq,
	input  cep_pkg::job_t               job,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cep_pkg::DIST_W-1:0]  track_distance,
	output cep_pkg::status_t            status
);
	import cep_pkg::*;

	typedef struct packed {
		logic            cap;
		status_t         status;
		logic [N2_W-1:0] n2;
		logic [T_W-1:0]  t;
	} div1_tag_t;

	typedef struct packed {
		status_t         status;
		logic [N2_W-1:0] n2;
		logic [T_W-1:0]  t;
	} sqrt_tag_t;

	typedef struct packed {
		logic    big;
		logic    neg;
		status_t status;
	} div2_tag_t;

	logic ben;

	logic              vld_s1, vld_s2, vld_s3;
	status_t           st_s1, st_s2, st_s3;
	logic [N2_W-1:0]   n2_s1, n2_s2, n2_s3;
	logic [T_W-1:0]    t_s1, t_s2, t_s3;
	logic [N2_W-1:0]   k_s1, k_s2, k_s3;
	logic [Q_W-1:0]    sqx_s1, sqy_s1, sqz_s1;
	logic [Q_W-1:0]    q_s2;
	logic [M_W-1:0]    m_s3;

	div1_tag_t         tag1_in, tag1_out;
	logic              d1_vld;
	logic [R2Q_W-1:0]  d1_quo;

	sqrt_tag_t         tag_sq_in, tag_sq_out;
	logic [RAD_W-1:0]  r2;
	logic              sq_vld;
	logic [ROOT_W-1:0] root;

	logic                vld_s4, vld_s5, vld_s6, vld_s7;
	status_t             st_s4, st_s5, st_s6, st_s7;
	logic [N2_W-1:0]     n2_s4, n2_s5, n2_s6, n2_s7;
	logic [NUM_W-1:0]    num_s4, mag_full;
	logic                neg_s5, neg_s6, neg_s7;
	logic [MAG_W-1:0]    mag_s5;
	logic [NUMER_W-1:0]  numer_s6, numer_s7;
	logic                big_s7;

	div2_tag_t           tag2_in, tag2_out;
	logic                d2_vld;
	logic [LQ_W-1:0]     lq;

	logic                out_vld_q;
	logic [DIST_W-1:0]   dist_q, dist_d;
	status_t             st_q, st_d;

	assign ben       = !(out_vld_q && out_stall);
	assign pop       = ben && !q_empty;
	assign out_valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (ben) begin
			vld_s1    <= pop;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= sq_vld;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			out_vld_q <= d2_vld;
		end
	end

	// squared cross terms, their sum, then times the cone term
	always_ff @(posedge clk) begin
		if (ben) begin
			st_s1  <= job.status;
			n2_s1  <= job.n2;
			t_s1   <= job.t;
			k_s1   <= job.k;
			sqx_s1 <= Q_W'(job.ax) * Q_W'(job.ax);
			sqy_s1 <= Q_W'(job.ay) * Q_W'(job.ay);
			sqz_s1 <= Q_W'(job.az) * Q_W'(job.az);

			st_s2  <= st_s1;
			n2_s2  <= n2_s1;
			t_s2   <= t_s1;
			k_s2   <= k_s1;
			q_s2   <= sqx_s1 + sqy_s1 + sqz_s1;

			st_s3  <= st_s2;
			n2_s3  <= n2_s2;
			t_s3   <= t_s2;
			k_s3   <= k_s2;
			m_s3   <= M_W'(q_s2) * M_W'(cos_sq);
		end
	end

	always_comb begin
		tag1_in.cap    = N2_W'(m_s3[M_W-1:50]) >= k_s3;
		tag1_in.status = st_s3;
		tag1_in.n2     = n2_s3;
		tag1_in.t      = t_s3;
	end

	cep_div #(
		.DW (N2_W),
		.QW (R2Q_W),
		.TW ($bits(div1_tag_t))
	) u_div_r2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (ben),
		.vld_in  (vld_s3),
		.hi      (N2_W'(m_s3[M_W-1:50])),
		.lo      ({m_s3[49:0], 12'h000}),
		.dvs     (k_s3),
		.tag_in  (tag1_in),
		.vld_out (d1_vld),
		.quo     (d1_quo),
		.tag_out (tag1_out)
	);

	always_comb begin
		r2                = tag1_out.cap ? (RAD_W'(1) << 62) : RAD_W'(d1_quo);
		tag_sq_in.status  = tag1_out.status;
		tag_sq_in.n2      = tag1_out.n2;
		tag_sq_in.t       = tag1_out.t;
	end

	cep_sqrt #(
		.TW ($bits(sqrt_tag_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (ben),
		.vld_in  (d1_vld),
		.rad     (r2),
		.tag_in  (tag_sq_in),
		.vld_out (sq_vld),
		.root    (root),
		.tag_out (tag_sq_out)
	);

	assign mag_full = num_s4[NUM_W-1] ? NUM_W'(~num_s4 + 1'b1) : num_s4;

	always_ff @(posedge clk) begin
		if (ben) begin
			st_s4    <= tag_sq_out.status;
			n2_s4    <= tag_sq_out.n2;
			num_s4   <= {{(NUM_W-T_W){tag_sq_out.t[T_W-1]}}, tag_sq_out.t}
			            - {1'b0, root, 12'h000};

			st_s5    <= st_s4;
			n2_s5    <= n2_s4;
			neg_s5   <= num_s4[NUM_W-1];
			mag_s5   <= mag_full[MAG_W-1:0];

			st_s6    <= st_s5;
			n2_s6    <= n2_s5;
			neg_s6   <= neg_s5;
			numer_s6 <= {1'b0, mag_s5, 14'h0000} + NUMER_W'(n2_s5 >> 1);

			st_s7    <= st_s6;
			n2_s7    <= n2_s6;
			neg_s7   <= neg_s6;
			numer_s7 <= numer_s6;
			big_s7   <= numer_s6[NUMER_W-1:LQ_W] >= {3'b000, n2_s6};
		end
	end

	always_comb begin
		tag2_in.big    = big_s7;
		tag2_in.neg    = neg_s7;
		tag2_in.status = st_s7;
	end

	cep_div #(
		.DW (N2_W),
		.QW (LQ_W),
		.TW ($bits(div2_tag_t))
	) u_div_lambda (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (ben),
		.vld_in  (vld_s7),
		.hi      (numer_s7[LQ_W +: N2_W]),
		.lo      (numer_s7[LQ_W-1:0]),
		.dvs     (n2_s7),
		.tag_in  (tag2_in),
		.vld_out (d2_vld),
		.quo     (lq),
		.tag_out (tag2_out)
	);

	// special cases and saturation
	always_comb begin
		if (tag2_out.status != ST_OK) begin
			dist_d = '0;
			st_d   = tag2_out.status;
		end else if (tag2_out.big) begin
			dist_d = tag2_out.neg ? DIST_MIN : DIST_MAX;
			st_d   = ST_SAT;
		end else if (tag2_out.neg) begin
			if (lq > DIST_MIN) begin
				dist_d = DIST_MIN;
				st_d   = ST_SAT;
			end else begin
				dist_d = ~lq + 1'b1;
				st_d   = ST_OK;
			end
		end else begin
			if (lq[LQ_W-1]) begin
				dist_d = DIST_MAX;
				st_d   = ST_SAT;
			end else begin
				dist_d = lq;
				st_d   = ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ben) begin
			dist_q <= dist_d;
			st_q   <= st_d;
		end
	end

	assign track_distance = dist_q;
	assign status         = st_q;

endmodule

// File: rtl/cherenkov_emission_point.sv
// top level of the cherenkov emission point block
//
//  channel   direction  handshake               beat
//  in        input      in_valid / in_stall     vertex, direction, sensor
//  out       output     out_valid / out_stall   track_distance, status
//  cfg       input      cfg_we / cfg_wdata      cos_sq_cone
//
//  one hit per cycle when nothing stalls; depth is set by the 62-stage
//  radius divider, the 32-stage square root and the 24-stage lambda divider
//  front and back pipelines stall independently across a small queue
//  out_stall freezes the back pipeline; in_stall rises while the queue is full
//  and the front holds a hit in its last stage
//  reset clears valids and loads cos_sq_cone with the 42 degree value
module cherenkov_emission_point #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [15:0]          vertex_x,
	input  logic signed [15:0]          vertex_y,
	input  logic signed [15:0]          vertex_z,
	input  logic signed [15:0]          dir_x,
	input  logic signed [15:0]          dir_y,
	input  logic signed [15:0]          dir_z,
	input  logic signed [15:0]          sensor_x,
	input  logic signed [15:0]          sensor_y,
	input  logic signed [15:0]          sensor_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [cep_pkg::DIST_W-1:0] track_distance,
	output logic [2:0]                  status,
	input  logic                        cfg_we,
	input  logic [15:0]                 cfg_wdata
);
	import cep_pkg::*;

	logic [15:0] cos_sq_cone_q;
	job_t        job_push, job_pop;
	logic        push, pop, q_full, q_empty;
	status_t     st;
	logic [DIST_W-1:0] distance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_sq_cone_q <= COS_SQ_RESET;
		end else if (cfg_we) begin
			cos_sq_cone_q <= cfg_wdata;
		end
	end

	cep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.vertex_x (vertex_x),
		.vertex_y (vertex_y),
		.vertex_z (vertex_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.sensor_x (sensor_x),
		.sensor_y (sensor_y),
		.sensor_z (sensor_z),
		.cos_sq   (cos_sq_cone_q),
		.q_full   (q_full),
		.push     (push),
		.job      (job_push)
	);

	cep_queue #(
		.W     ($bits(job_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_push),
		.pop    (pop),
		.rdata  (job_pop),
		.full   (q_full),
		.empty  (q_empty)
	);

	cep_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cos_sq         (cos_sq_cone_q),
		.job            (job_pop),
		.q_empty        (q_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.track_distance (distance),
		.status         (st)
	);

	assign track_distance = distance;
	assign status         = st;

endmodule

// File: verif/tb.sv
// testbench for the cherenkov emission point block: directed and random hits
`timescale 1ns / 100ps

module tb;
	import cep_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic signed [15:0] vertex_x;
		logic signed [15:0] vertex_y;
		logic signed [15:0] vertex_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] sensor_x;
		logic signed [15:0] sensor_y;
		logic signed [15:0] sensor_z;
	} hit_t;

	typedef struct packed {
		logic [DIST_W-1:0] track_distance;
		status_t           status;
	} emission_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] vertex_x, vertex_y, vertex_z;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic signed [15:0] sensor_x, sensor_y, sensor_z;
	logic out_valid;
	logic out_stall;
	logic signed [DIST_W-1:0] track_distance;
	logic [2:0] status;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	logic [15:0] cos_sq_model;
	emission_t expected_emissions[$];
	int errors;
	bit idling;
	int stall_left;
	longint cycles;

	cherenkov_emission_point u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.vertex_z(vertex_z),
		.dir_x(dir_x),
		.dir_y(dir_y),
		.dir_z(dir_z),
		.sensor_x(sensor_x),
		.sensor_y(sensor_y),
		.sensor_z(sensor_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.track_distance(track_distance),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 85) begin
			return $urandom_range(0, 2);
		end else if (roll < 97) begin
			return $urandom_range(3, 8);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic emission_t predict_emission(hit_t h);
		longint dx, dy, dz, ex, ey, ez, n2, t, cx, cy, cz, c, k, num;
		longint unsigned ax, ay, az, q, m, quo, rem, r2, r, mag, lq, x, bit_v;
		emission_t e;
		dx = h.dir_x;
		dy = h.dir_y;
		dz = h.dir_z;
		ex = longint'(h.sensor_x) - longint'(h.vertex_x);
		ey = longint'(h.sensor_y) - longint'(h.vertex_y);
		ez = longint'(h.sensor_z) - longint'(h.vertex_z);
		n2 = dx * dx + dy * dy + dz * dz;
		t = dx * ex + dy * ey + dz * ez;
		cx = dy * ez - dz * ey;
		cy = dz * ex - dx * ez;
		cz = dx * ey - dy * ex;
		c = longint'({48'd0, cos_sq_model});
		k = n2 - c * 4096;
		e.track_distance = '0;
		if (n2 == 0 || k == 0) begin
			e.status = ST_DEGEN;
			return e;
		end
		if (k < 0 && c > 0 && !(cx == 0 && cy == 0 && cz == 0)) begin
			e.status = ST_NOROOT;
			return e;
		end
		if (c == 0 || (cx == 0 && cy == 0 && cz == 0)) begin
			e.status = ST_TIE;
			return e;
		end
		ax = (cx < 0 ? -cx : cx) >> 12;
		ay = (cy < 0 ? -cy : cy) >> 12;
		az = (cz < 0 ? -cz : cz) >> 12;
		q = ax * ax + ay * ay + az * az;
		m = q * longint'(c);
		quo = m / longint'(k);
		rem = m % longint'(k);
		if (quo >= (64'd1 << 50)) begin
			r2 = 64'd1 << 62;
		end else begin
			r2 = (quo << 12) + ((rem << 12) / longint'(k));
		end
		if (r2 > (64'd1 << 62)) begin
			r2 = 64'd1 << 62;
		end
		// bitwise integer square root
		x = r2;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) begin
			bit_v = bit_v >> 2;
		end
		while (bit_v != 0) begin
			if (x >= r + bit_v) begin
				x = x - (r + bit_v);
				r = (r >> 1) + bit_v;
			end else begin
				r = r >> 1;
			end
			bit_v = bit_v >> 2;
		end
		num = t - longint'(r) * 4096;
		mag = num < 0 ? -num : num;
		lq = (mag * 16384 + longint'(n2) / 2) / longint'(n2);
		e.status = ST_OK;
		if (num < 0) begin
			if (lq > 64'd8388608) begin
				e.track_distance = DIST_MIN;
				e.status = ST_SAT;
			end else begin
				e.track_distance = DIST_W'(-lq);
			end
		end else begin
			if (lq > 64'd8388607) begin
				e.track_distance = DIST_MAX;
				e.status = ST_SAT;
			end else begin
				e.track_distance = DIST_W'(lq);
			end
		end
		return e;
	endfunction

	task automatic send_hit(hit_t h);
		int gap;
		gap = idling ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		vertex_x <= h.vertex_x;
		vertex_y <= h.vertex_y;
		vertex_z <= h.vertex_z;
		dir_x <= h.dir_x;
		dir_y <= h.dir_y;
		dir_z <= h.dir_z;
		sensor_x <= h.sensor_x;
		sensor_y <= h.sensor_y;
		sensor_z <= h.sensor_z;
		do @(posedge clk); while (in_stall);
		expected_emissions.push_back(predict_emission(h));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_emissions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cos_sq(logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cos_sq_model = value;
	endtask

	function automatic hit_t make_hit(int vx, int vy, int vz, int dx, int dy, int dz,
			int px, int py, int pz);
		hit_t h;
		h.vertex_x = 16'(vx);
		h.vertex_y = 16'(vy);
		h.vertex_z = 16'(vz);
		h.dir_x = 16'(dx);
		h.dir_y = 16'(dy);
		h.dir_z = 16'(dz);
		h.sensor_x = 16'(px);
		h.sensor_y = 16'(py);
		h.sensor_z = 16'(pz);
		return h;
	endfunction

	function automatic hit_t random_hit();
		hit_t h;
		h.vertex_x = 16'($urandom);
		h.vertex_y = 16'($urandom);
		h.vertex_z = 16'($urandom);
		h.dir_x = 16'($urandom);
		h.dir_y = 16'($urandom);
		h.dir_z = 16'($urandom);
		h.sensor_x = 16'($urandom);
		h.sensor_y = 16'($urandom);
		h.sensor_z = 16'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			// near-unit direction and positions inside a detector-sized volume
			h.dir_x = 16'($urandom_range(0, 32768) - 16384);
			h.dir_y = 16'($urandom_range(0, 32768) - 16384);
			h.dir_z = 16'($urandom_range(0, 32768) - 16384);
			h.vertex_x = 16'($urandom_range(0, 20000) - 10000);
			h.vertex_y = 16'($urandom_range(0, 20000) - 10000);
			h.vertex_z = 16'($urandom_range(0, 20000) - 10000);
			h.sensor_x = 16'($urandom_range(0, 40000) - 20000);
			h.sensor_y = 16'($urandom_range(0, 40000) - 20000);
			h.sensor_z = 16'($urandom_range(0, 40000) - 20000);
		end
		return h;
	endfunction

	task automatic test_directed();
		idling = 1'b0;
		send_hit(make_hit(0, 0, 0, 16384, 0, 0, 3000, 2000, 0));
		send_hit(make_hit(0, 0, 0, 0, 0, 0, 100, 100, 100));
		send_hit(make_hit(0, 0, 0, 1, 0, 0, 500, 500, 0));
		send_hit(make_hit(0, 0, 0, 16384, 0, 0, 5000, 0, 0));
		send_hit(make_hit(-32768, -32768, -32768, 16384, 0, 0, 32767, 32767, 32767));
		send_hit(make_hit(32767, 32767, 32767, -32768, -32768, -32768,
			-32768, -32768, -32768));
		send_hit(make_hit(32767, -32768, 0, 32767, 32767, 32767,
			-32768, 32767, 0));
		send_hit(make_hit(-32768, 0, 32767, -32768, 32767, -32768,
			32767, -32768, -32768));
		send_hit(make_hit(0, 0, 0, 0, 16384, 16384, 100, -9000, 7000));
		send_hit(make_hit(-1, -1, -1, -1, -1, -1, 0, 0, 0));
		drain();
		write_cos_sq(16'd1);
		send_hit(make_hit(-30000, 0, 0, 100, 0, 0, 30000, 1000, 0));
		send_hit(make_hit(30000, 0, 0, 100, 0, 0, -30000, 1000, 0));
		send_hit(make_hit(0, 0, 0, 64, 0, 0, 2000, 300, 0));
		send_hit(make_hit(0, 0, 0, 100, 0, 0, 800, 0, 0));
		drain();
		write_cos_sq(16'd0);
		send_hit(make_hit(0, 0, 0, 16384, 0, 0, 3000, 2000, 0));
		send_hit(make_hit(0, 0, 0, 0, 0, 0, 3000, 2000, 0));
		drain();
		write_cos_sq(16'hFFFF);
		send_hit(make_hit(0, 0, 0, 16384, 0, 0, 3000, 2000, 0));
		send_hit(make_hit(0, 0, 0, 32767, 0, 0, 3000, 2000, 0));
		send_hit(make_hit(0, 0, 0, 16384, 0, 0, 3000, 0, 0));
		send_hit(make_hit(0, 0, 0, 16383, 1, 0, -3000, 2000, 900));
		drain();
		// direction length exactly on the cone: k zero
		write_cos_sq(16'd16384);
		send_hit(make_hit(0, 0, 0, 8192, 0, 0, 3000, 2000, 0));
		drain();
	endtask

	task automatic test_random(logic [15:0] cos_sq, int count);
		write_cos_sq(cos_sq);
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0) begin
				idling = $urandom_range(0, 3) != 0;
			end
			send_hit(random_hit());
		end
		drain();
	endtask

	always @(posedge clk) begin
		emission_t e;
		if (out_valid && !out_stall) begin
			if (expected_emissions.size() == 0) begin
				$error("unexpected beat: track_distance %0d status %0d",
					track_distance, status);
				errors++;
			end else begin
				e = expected_emissions.pop_front();
				if (track_distance !== e.track_distance) begin
					$error("track_distance expected %0d actual %0d",
						$signed(e.track_distance), track_distance);
					errors++;
				end
				if (status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, status);
					errors++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		stall_left = 0;
		idling = 1'b0;
		cos_sq_model = COS_SQ_RESET;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		{vertex_x, vertex_y, vertex_z, dir_x, dir_y, dir_z} <= '0;
		{sensor_x, sensor_y, sensor_z} <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_random(COS_SQ_RESET, 350);
		test_directed();
		test_random(16'd0, 30);
		test_random(16'hFFFF, 120);
		test_random(16'd1, 60);
		test_random(16'($urandom_range(0, 65535)), 200);
		test_random(16'd36195, 170);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
